### design/qbps_pkg.sv
// Shared types, widths and helpers for the quadratic Bezier parameter solver.
// Depends on nothing; every other design file imports it.
package qbps_pkg;

  // Field widths
  localparam int CW    = 32;            // coordinate, signed Q16.16
  localparam int TW    = 32;            // t value, signed
  localparam int TOLW  = 16;            // tolerance
  localparam int F     = 24;            // fraction bits of t (16..30)

  // Internal widths
  localparam int AW    = CW + 2;        // a and b coefficients
  localparam int CMPW  = CW + 1;        // c - p
  localparam int SQ_RW = 35;            // square root bits
  localparam int DW    = 2 * SQ_RW;     // discriminant / radicand
  localparam int SQ_REMW = SQ_RW + 2;   // square root remainder
  localparam int MW    = SQ_RW + 2;     // signed numerator -b +/- s
  localparam int DENW  = AW + 2;        // signed divisor
  localparam int UMW   = MW;            // numerator magnitude
  localparam int UDW   = DENW;          // divisor magnitude
  localparam int QW    = TW - 1;        // quotient bits before saturation
  localparam int KSH   = QW - F;        // numerator bits above the quotient window
  localparam int ATW   = AW + TW;       // a*t
  localparam int UW    = ATW - F + 1;   // u = floor(a*t) + b
  localparam int UL    = 21;            // low slice of u in the split u*t product
  localparam int UHW   = UW - UL;       // signed high slice of u
  localparam int UPW   = UHW + TW;      // one partial product of u*t
  localparam int UTW   = UW + TW;       // u*t
  localparam int RRW   = UTW - F + 1;   // residual

  // Latencies in cycles
  localparam int SQRT_LAT  = SQ_RW;
  localparam int DIV_LAT   = QW + 2;
  localparam int AXIS_LAT  = 4 + SQRT_LAT + DIV_LAT;
  localparam int RES_LAT   = 5;
  localparam int TOTAL_LAT = AXIS_LAT + RES_LAT + 1;

  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_CTRL_X    = 3'd2,
    REG_CTRL_Y    = 3'd3,
    REG_END_X     = 3'd4,
    REG_END_Y     = 3'd5,
    REG_TOLERANCE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [TW-1:0] t_value;
    logic                 found;
    logic                 solved_axis;
  } result_t;

  // Both roots of one axis
  typedef struct packed {
    logic signed [TW-1:0] t_plus;
    logic signed [TW-1:0] t_minus;
    logic                 ok_plus;
    logic                 ok_minus;
  } root_pair_t;

  // One checked root
  typedef struct packed {
    logic signed [TW-1:0] t;
    logic                 ok;
    logic                 pass;
  } checked_t;

  // t^2 coefficient: S - 2C + E
  function automatic logic signed [AW-1:0] coef_a(input logic signed [CW-1:0] s,
                                                  input logic signed [CW-1:0] c,
                                                  input logic signed [CW-1:0] e);
    return AW'(s) - (AW'(c) <<< 1) + AW'(e);
  endfunction

  // t coefficient: 2(C - S)
  function automatic logic signed [AW-1:0] coef_b(input logic signed [CW-1:0] s,
                                                  input logic signed [CW-1:0] c);
    return (AW'(c) - AW'(s)) <<< 1;
  endfunction

endpackage

### design/qbps_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on qbps_pkg.
module qbps_sqrt import qbps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [DW-1:0]      rad_i,
  output logic               valid_o,
  output logic [SQ_RW-1:0]   root_o
);

  logic [DW-1:0]      rad_q  [SQ_RW];
  logic [SQ_REMW-1:0] rem_q  [SQ_RW];
  logic [SQ_RW-1:0]   root_q [SQ_RW];
  logic [SQ_RW-1:0]   vld_q;

  for (genvar g = 0; g < SQ_RW; g++) begin : g_stage
    logic [DW-1:0]      rad_in;
    logic [SQ_REMW-1:0] rem_in;
    logic [SQ_RW-1:0]   root_in;
    logic               vld_in;
    logic [SQ_REMW+1:0] cand;
    logic [SQ_REMW+1:0] trial;
    logic               take;

    if (g == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // bring down the next bit pair, try root*4+1
    assign cand  = {rem_in, rad_in[2*(SQ_RW-1-g)+1 -: 2]};
    assign trial = (SQ_REMW+2)'({root_in, 2'b01});
    assign take  = (cand >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g]  <= rad_in;
      rem_q[g]  <= take ? SQ_REMW'(cand - trial) : SQ_REMW'(cand);
      root_q[g] <= {root_in[SQ_RW-2:0], take};
    end
  end

  assign valid_o = vld_q[SQ_RW-1];
  assign root_o  = root_q[SQ_RW-1];

endmodule

### design/qbps_div.sv
// Pipelined signed divide t = m * 2^F / den, truncated and saturated to TW bits.
// Depends on qbps_pkg. One prepare stage, one stage per quotient bit, one saturate stage.
module qbps_div import qbps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [MW-1:0]   num_i,
  input  logic signed [DENW-1:0] den_i,
  output logic                   valid_o,
  output logic signed [TW-1:0]   t_o,
  output logic                   ok_o
);

  // Prepare stage
  logic [UMW-1:0] um;
  logic [UDW-1:0] ud;
  logic [UMW-1:0] um_hi;

  logic           pv_q;
  logic [UDW-1:0] pud_q;
  logic [UDW-1:0] prem_q;
  logic [QW-1:0]  pnlo_q;
  logic           pneg_q, pzero_q, povf_q;

  assign um    = num_i[MW-1] ? UMW'(-num_i) : UMW'(num_i);
  assign ud    = den_i[DENW-1] ? UDW'(-den_i) : UDW'(den_i);
  assign um_hi = um >> KSH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pud_q   <= ud;
    prem_q  <= UDW'(um_hi);
    pnlo_q  <= QW'({um, {F{1'b0}}});
    pneg_q  <= num_i[MW-1] ^ den_i[DENW-1];
    pzero_q <= (den_i == '0);
    povf_q  <= (um_hi >= UMW'(ud));
  end

  // Quotient stages
  logic [QW-1:0]  vld_q;
  logic [UDW-1:0] ud_q   [QW];
  logic [UDW-1:0] rem_q  [QW];
  logic [QW-1:0]  nlo_q  [QW];
  logic [QW-1:0]  quo_q  [QW];
  logic [QW-1:0]  neg_q, zero_q, ovf_q;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic           vld_in, neg_in, zero_in, ovf_in;
    logic [UDW-1:0] ud_in, rem_in;
    logic [QW-1:0]  nlo_in, quo_in;
    logic [UDW:0]   cand;
    logic           ge;

    if (j == 0) begin : g_first
      assign vld_in  = pv_q;
      assign ud_in   = pud_q;
      assign rem_in  = prem_q;
      assign nlo_in  = pnlo_q;
      assign quo_in  = '0;
      assign neg_in  = pneg_q;
      assign zero_in = pzero_q;
      assign ovf_in  = povf_q;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign ud_in   = ud_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign nlo_in  = nlo_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign neg_in  = neg_q[j-1];
      assign zero_in = zero_q[j-1];
      assign ovf_in  = ovf_q[j-1];
    end

    // restoring step on the next numerator bit
    assign cand = {rem_in, nlo_in[QW-1-j]};
    assign ge   = (cand >= {1'b0, ud_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ud_q[j]   <= ud_in;
      rem_q[j]  <= ge ? UDW'(cand - {1'b0, ud_in}) : UDW'(cand);
      nlo_q[j]  <= nlo_in;
      quo_q[j]  <= {quo_in[QW-2:0], ge};
      neg_q[j]  <= neg_in;
      zero_q[j] <= zero_in;
      ovf_q[j]  <= ovf_in;
    end
  end

  // Sign and saturate
  logic                 sv_q;
  logic signed [TW-1:0] t_q;
  logic                 ok_q;
  logic signed [TW-1:0] t_d;
  logic signed [TW-1:0] qpos;

  assign qpos = $signed({1'b0, quo_q[QW-1]});

  always_comb begin
    if (ovf_q[QW-1]) begin
      t_d = neg_q[QW-1] ? T_MIN : T_MAX;
    end else begin
      t_d = neg_q[QW-1] ? -qpos : qpos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    ok_q <= !zero_q[QW-1];
  end

  assign valid_o = sv_q;
  assign t_o     = t_q;
  assign ok_o    = ok_q;

endmodule

### design/qbps_axis.sv
// Solves a*t^2 + b*t + c = p for one axis: discriminant, square root, both roots.
// Depends on qbps_pkg, qbps_sqrt and qbps_div.
module qbps_axis import qbps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [AW-1:0]   b_i,
  input  logic signed [CW-1:0]   c_i,
  input  logic signed [CW-1:0]   p_i,
  output logic                   valid_o,
  output root_pair_t             roots_o,
  output logic signed [CMPW-1:0] cmp_o
);

  typedef struct packed {
    logic signed [CMPW-1:0] cmp;
    logic                   negd;
  } side_t;

  // Stage A0: c - p
  logic                   v0_q;
  logic signed [CMPW-1:0] cmp0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp0_q <= CMPW'(c_i) - CMPW'(p_i);
  end

  // Stage A1: b*b and a*(c - p)
  logic                          v1_q;
  logic signed [2*AW-1:0]        bb_q;
  logic signed [AW+CMPW-1:0]     ac_q;
  logic signed [CMPW-1:0]        cmp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q   <= b_i * b_i;
    ac_q   <= a_i * cmp0_q;
    cmp1_q <= cmp0_q;
  end

  // Stage A2: discriminant
  logic                 v2_q;
  logic signed [DW-1:0] d_d;
  logic signed [DW-1:0] d_q;
  side_t                side2_q;

  assign d_d = DW'(bb_q) - (DW'(ac_q) <<< 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q          <= d_d;
    side2_q.cmp  <= cmp1_q;
    side2_q.negd <= d_d[DW-1];
  end

  // Square root, side data delayed alongside
  logic             sq_vld;
  logic [SQ_RW-1:0] sq_root;
  side_t            sq_side_q [SQRT_LAT];

  qbps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .rad_i   (side2_q.negd ? '0 : $unsigned(d_q)),
    .valid_o (sq_vld),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i) begin
    sq_side_q[0] <= side2_q;
    for (int i = 1; i < SQRT_LAT; i++) begin
      sq_side_q[i] <= sq_side_q[i-1];
    end
  end

  // Stage R: numerators and divisor; linear when a is zero
  logic                   vr_q;
  logic signed [MW-1:0]   mp_q, mm_q;
  logic signed [DENW-1:0] den_q;
  side_t                  sider_q;
  logic signed [MW-1:0]   s_ext;
  logic                   lin;

  assign s_ext = MW'($signed({1'b0, sq_root}));
  assign lin   = (a_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lin) begin
      mp_q  <= -MW'(sq_side_q[SQRT_LAT-1].cmp);
      mm_q  <= -MW'(sq_side_q[SQRT_LAT-1].cmp);
      den_q <= DENW'(b_i);
    end else begin
      mp_q  <= s_ext - MW'(b_i);
      mm_q  <= -MW'(b_i) - s_ext;
      den_q <= DENW'(a_i) <<< 1;
    end
    sider_q <= sq_side_q[SQRT_LAT-1];
  end

  // Dividers for the plus and minus roots
  logic                 dp_vld, dm_vld, dp_ok, dm_ok;
  logic signed [TW-1:0] dp_t, dm_t;
  side_t                dv_side_q [DIV_LAT];

  qbps_div u_div_plus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vr_q),
    .num_i   (mp_q),
    .den_i   (den_q),
    .valid_o (dp_vld),
    .t_o     (dp_t),
    .ok_o    (dp_ok)
  );

  qbps_div u_div_minus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vr_q),
    .num_i   (mm_q),
    .den_i   (den_q),
    .valid_o (dm_vld),
    .t_o     (dm_t),
    .ok_o    (dm_ok)
  );

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= sider_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      dv_side_q[i] <= dv_side_q[i-1];
    end
  end

  // a negative discriminant voids both roots
  assign valid_o          = dp_vld & dm_vld;
  assign roots_o.t_plus   = dp_t;
  assign roots_o.t_minus  = dm_t;
  assign roots_o.ok_plus  = dp_ok & !dv_side_q[DIV_LAT-1].negd;
  assign roots_o.ok_minus = dm_ok & !dv_side_q[DIV_LAT-1].negd;
  assign cmp_o            = dv_side_q[DIV_LAT-1].cmp;

endmodule

### design/qbps_resid.sv
// Checks one root against the other axis: |(a*t + b)*t + c - p| < tolerance.
// Depends on qbps_pkg. Five register stages.
module qbps_resid import qbps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [AW-1:0]   b_i,
  input  logic signed [CMPW-1:0] cmp_i,
  input  logic signed [TW-1:0]   t_i,
  input  logic                   ok_i,
  input  logic [TOLW-1:0]        tol_i,
  output logic                   valid_o,
  output checked_t               chk_o
);

  // P0: a*t
  logic                   v0_q, ok0_q;
  logic signed [ATW-1:0]  at_q;
  logic signed [TW-1:0]   t0_q;
  logic signed [CMPW-1:0] cmp0_q;

  // P1: u = floor(a*t) + b
  logic                   v1_q, ok1_q;
  logic signed [UW-1:0]   u_q;
  logic signed [TW-1:0]   t1_q;
  logic signed [CMPW-1:0] cmp1_q;

  // P2: u*t as two narrow partial products
  logic                   v2_q, ok2_q;
  logic signed [UHW-1:0]  uh;
  logic signed [UL:0]     ul;
  logic signed [UPW-1:0]  uth_q, utl_q;
  logic signed [TW-1:0]   t2_q;
  logic signed [CMPW-1:0] cmp2_q;

  // P3: residual
  logic                   v3_q, ok3_q;
  logic signed [UTW-1:0]  ut;
  logic signed [RRW-1:0]  r_q;
  logic signed [TW-1:0]   t3_q;

  // P4: magnitude compare
  logic                   v4_q;
  logic [RRW-1:0]         rmag;
  checked_t               chk_q;

  assign uh   = u_q[UW-1:UL];
  assign ul   = $signed({1'b0, u_q[UL-1:0]});
  assign ut   = (UTW'(uth_q) <<< UL) + UTW'(utl_q);
  assign rmag = r_q[RRW-1] ? RRW'(-r_q) : RRW'(r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q       <= a_i * t_i;
    t0_q       <= t_i;
    ok0_q      <= ok_i;
    cmp0_q     <= cmp_i;
    u_q        <= UW'(at_q >>> F) + UW'(b_i);
    t1_q       <= t0_q;
    ok1_q      <= ok0_q;
    cmp1_q     <= cmp0_q;
    uth_q      <= uh * t1_q;
    utl_q      <= ul * t1_q;
    t2_q       <= t1_q;
    ok2_q      <= ok1_q;
    cmp2_q     <= cmp1_q;
    r_q        <= RRW'(ut >>> F) + RRW'(cmp2_q);
    t3_q       <= t2_q;
    ok3_q      <= ok2_q;
    chk_q.t    <= t3_q;
    chk_q.ok   <= ok3_q;
    chk_q.pass <= ok3_q && (rmag < RRW'(tol_i));
  end

  assign valid_o = v4_q;
  assign chk_o   = chk_q;

endmodule

### design/quadratic_bezier_param_solve_unit.sv
// Quadratic Bezier inverse parameter solver, top level.
// Depends on qbps_pkg, qbps_axis (with qbps_sqrt, qbps_div) and qbps_resid.
//
// Usage:
//   Write the curve's start, control and end points and the tolerance through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no query is in flight.
//   A query transfer happens on a clock edge with start_i high and busy_o low;
//   busy_o is always low, so one point can be issued every cycle.
//   Each query yields exactly one result, shown on result_o for one cycle with
//   done_o high; results leave in query order.
//   The receiver cannot stall the output.
//   Throughput is one query per cycle; latency is set by the 35-stage square
//   root and the two 31-bit-quotient dividers per axis, which work on both axes
//   at once, then a 5-stage residual check of all four roots and a select stage.
//   Reset clears every pipeline valid bit, drops queries in flight and loads the
//   register defaults: start (0,0), control (0,0), end (1.0,0), tolerance 1.
module quadratic_bezier_param_solve_unit import qbps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  point_t          point_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CW-1:0]   cfg_wdata_i,
  output logic            done_o,
  output result_t         result_o
);

  // Configuration registers
  logic signed [CW-1:0] start_x_q, start_y_q, ctrl_x_q, ctrl_y_q, end_x_q, end_y_q;
  logic [TOLW-1:0]      tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      ctrl_x_q  <= '0;
      ctrl_y_q  <= '0;
      end_x_q   <= CW'(32'sd65536);
      end_y_q   <= '0;
      tol_q     <= TOLW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START_X:   start_x_q <= cfg_wdata_i;
        REG_START_Y:   start_y_q <= cfg_wdata_i;
        REG_CTRL_X:    ctrl_x_q  <= cfg_wdata_i;
        REG_CTRL_Y:    ctrl_y_q  <= cfg_wdata_i;
        REG_END_X:     end_x_q   <= cfg_wdata_i;
        REG_END_Y:     end_y_q   <= cfg_wdata_i;
        REG_TOLERANCE: tol_q     <= cfg_wdata_i[TOLW-1:0];
        default: ;
      endcase
    end
  end

  // Curve coefficients; the user must keep them stable while queries are in flight, the block does not enforce it
  logic signed [AW-1:0] ax, bx, ay, by;

  assign ax = coef_a(start_x_q, ctrl_x_q, end_x_q);
  assign bx = coef_b(start_x_q, ctrl_x_q);
  assign ay = coef_a(start_y_q, ctrl_y_q, end_y_q);
  assign by = coef_b(start_y_q, ctrl_y_q);

  // Always ready: a new query can enter every cycle
  logic take;

  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  // Solve both axes side by side
  logic                   xv, yv;
  root_pair_t             xr, yr;
  logic signed [CMPW-1:0] xcmp, ycmp;

  qbps_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .a_i     (ax),
    .b_i     (bx),
    .c_i     (start_x_q),
    .p_i     (point_i.point_x),
    .valid_o (xv),
    .roots_o (xr),
    .cmp_o   (xcmp)
  );

  qbps_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .a_i     (ay),
    .b_i     (by),
    .c_i     (start_y_q),
    .p_i     (point_i.point_y),
    .valid_o (yv),
    .roots_o (yr),
    .cmp_o   (ycmp)
  );

  // x roots checked in y, y roots checked in x
  logic     xp_v, xm_v, yp_v, ym_v;
  checked_t xp_c, xm_c, yp_c, ym_c;

  qbps_resid u_chk_xp (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (xv),
    .a_i (ay), .b_i (by), .cmp_i (ycmp), .t_i (xr.t_plus), .ok_i (xr.ok_plus),
    .tol_i (tol_q), .valid_o (xp_v), .chk_o (xp_c)
  );

  qbps_resid u_chk_xm (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (xv),
    .a_i (ay), .b_i (by), .cmp_i (ycmp), .t_i (xr.t_minus), .ok_i (xr.ok_minus),
    .tol_i (tol_q), .valid_o (xm_v), .chk_o (xm_c)
  );

  qbps_resid u_chk_yp (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (yv),
    .a_i (ax), .b_i (bx), .cmp_i (xcmp), .t_i (yr.t_plus), .ok_i (yr.ok_plus),
    .tol_i (tol_q), .valid_o (yp_v), .chk_o (yp_c)
  );

  qbps_resid u_chk_ym (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (yv),
    .a_i (ax), .b_i (bx), .cmp_i (xcmp), .t_i (yr.t_minus), .ok_i (yr.ok_minus),
    .tol_i (tol_q), .valid_o (ym_v), .chk_o (ym_c)
  );

  // Priority select: x plus, x minus, y plus, y minus, else y plus unfound
  logic    done_q;
  result_t res_d, res_q;

  always_comb begin
    if (xp_c.pass) begin
      res_d = '{t_value: xp_c.t, found: 1'b1, solved_axis: 1'b0};
    end else if (xm_c.pass) begin
      res_d = '{t_value: xm_c.t, found: 1'b1, solved_axis: 1'b0};
    end else if (yp_c.pass) begin
      res_d = '{t_value: yp_c.t, found: 1'b1, solved_axis: 1'b1};
    end else if (ym_c.pass) begin
      res_d = '{t_value: ym_c.t, found: 1'b1, solved_axis: 1'b1};
    end else begin
      res_d = '{t_value: (yp_c.ok ? yp_c.t : '0), found: 1'b0, solved_axis: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= xp_v & xm_v & yp_v & ym_v;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // Checks
  a_axes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    xv == yv)
    else $error("axis pipelines out of step");

  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##TOTAL_LAT done_o)
    else $error("query transfer without a result");

  a_latency_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, TOTAL_LAT))
    else $error("result without a query transfer");

  a_unfound_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.found |-> result_o.solved_axis)
    else $error("unfound result must come from the y solve");

endmodule
